/* rtl/nbg_pkg.sv */
// Shared types, constants and saturating helpers of the gravity step block.
package nbg_pkg;

    localparam int MAX_BODIES  = 8;
    localparam int COORD_WIDTH = 48;
    localparam int IDX_W       = $clog2(MAX_BODIES);
    localparam int CNT_W       = $clog2(MAX_BODIES + 1);
    localparam int ALU_W       = 128;
    localparam int ITER_W      = $clog2(ALU_W);
    localparam int D2_W        = 2 * COORD_WIDTH;
    localparam int Q_W         = 64;
    localparam int W_W         = ALU_W - COORD_WIDTH;
    localparam int W_SHIFT     = 40;
    localparam int MASS_W      = 32;
    localparam int SPEED_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int MUL_ITER  = COORD_WIDTH;
    localparam int DIV_ITER  = ALU_W;
    localparam int SQRT_ITER = ALU_W / 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [COORD_WIDTH-1:0]        umag_t;

    localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY = 2'd0,
        REG_SPEED   = 2'd1,
        REG_COUNT   = 2'd2,
        REG_RUN     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t vx;
        coord_t vy;
    } kin_t;

    typedef struct packed {
        logic                   command;
        logic [2:0]             body_index;
        logic [MASS_W-1:0]      body_mass;
        logic signed [47:0]     load_pos_x;
        logic signed [47:0]     load_pos_y;
        logic signed [47:0]     load_vel_x;
        logic signed [47:0]     load_vel_y;
    } nbg_in_t;

    typedef struct packed {
        logic [2:0]             out_index;
        logic signed [47:0]     out_pos_x;
        logic signed [47:0]     out_pos_y;
        logic signed [47:0]     out_vel_x;
        logic signed [47:0]     out_vel_y;
        logic                   last_body;
    } nbg_out_t;

    function automatic coord_t sat_add(coord_t a, coord_t b);
        logic signed [COORD_WIDTH:0] s;
        coord_t r;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            r = s[COORD_WIDTH] ? CMIN : CMAX;
        end else begin
            r = s[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic coord_t sat_sub(coord_t a, coord_t b);
        logic signed [COORD_WIDTH:0] s;
        coord_t r;
        s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            r = s[COORD_WIDTH] ? CMIN : CMAX;
        end else begin
            r = s[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic umag_t mag(coord_t v);
        umag_t u;
        u = v;
        return u[COORD_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

/* rtl/nbg_ram.sv */
// Generic single-write, single-read memory with registered read data.
module nbg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/nbg_alu.sv */
// Shared bit-serial arithmetic unit: multiply, divide and square root on one adder.
module nbg_alu import nbg_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  alu_req_t         req,
    input  logic [ALU_W-1:0] opa,
    input  logic [ALU_W-1:0] opb,
    output alu_stat_t        stat,
    output logic [ALU_W-1:0] res
);

    logic [ALU_W-1:0]  acc_reg, acc_next;
    logic [ALU_W-1:0]  x_reg, x_next;
    logic [ALU_W-1:0]  y_reg, y_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    alu_op_t           op_reg, op_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [ALU_W-1:0]  add_a, add_b;
    logic              sub;
    logic [ALU_W:0]    sum;
    logic              ge;

    always_comb begin
        case (op_reg)
            ALU_MUL: begin
                add_a = acc_reg;
                add_b = x_reg;
                sub   = 1'b0;
            end
            ALU_DIV: begin
                add_a = {acc_reg[ALU_W-2:0], x_reg[ALU_W-1]};
                add_b = y_reg;
                sub   = 1'b1;
            end
            ALU_SQRT: begin
                add_a = {acc_reg[ALU_W-3:0], x_reg[ALU_W-1:ALU_W-2]};
                add_b = {y_reg[ALU_W-3:0], 2'b01};
                sub   = 1'b1;
            end
            default: begin
                add_a = acc_reg;
                add_b = '0;
                sub   = 1'b0;
            end
        endcase
        sum = {1'b0, add_a} + {1'b0, sub ? ~add_b : add_b} + {{ALU_W{1'b0}}, sub};
        ge  = sum[ALU_W];
    end

    always_comb begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next  = '0;
            x_next    = opa;
            y_next    = opb;
            op_next   = req.op;
            busy_next = 1'b1;
            case (req.op)
                ALU_MUL:  cnt_next = ITER_W'(MUL_ITER - 1);
                ALU_DIV:  cnt_next = ITER_W'(DIV_ITER - 1);
                ALU_SQRT: cnt_next = ITER_W'(SQRT_ITER - 1);
                default:  cnt_next = '0;
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                ALU_MUL: begin
                    acc_next = y_reg[0] ? sum[ALU_W-1:0] : acc_reg;
                    x_next   = {x_reg[ALU_W-2:0], 1'b0};
                    y_next   = {1'b0, y_reg[ALU_W-1:1]};
                end
                ALU_DIV: begin
                    acc_next = ge ? sum[ALU_W-1:0] : add_a;
                    x_next   = {x_reg[ALU_W-2:0], ge};
                end
                ALU_SQRT: begin
                    acc_next = ge ? sum[ALU_W-1:0] : add_a;
                    x_next   = {x_reg[ALU_W-3:0], 2'b00};
                    y_next   = {y_reg[ALU_W-2:0], ge};
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        case (op_reg)
            ALU_MUL:  res = acc_reg;
            ALU_DIV:  res = x_reg;
            ALU_SQRT: res = y_reg;
            default:  res = acc_reg;
        endcase
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/nbody_gravity_step.sv */
// Top level of the two-dimensional direct-summation gravity step block.
// A load request writes one body slot. A tick request that starts a burst keeps
// the block busy through every step: the pair work, the per-body bookkeeping and
// the commit, for the n bodies in use. Every interacting pair passes through
// the shared iterative unit for two squares, one square root, four more products,
// one 128-bit quotient and two component quotients. A coincident pair ends after
// the two squares. The n results then leave one at a time, each read in ST_ERD
// and loaded in ST_EMIT once the output register is free or being taken. A tick
// that runs no burst leaves the block idle. The block takes no new request until
// the burst has been handed to the output register.
module nbody_gravity_step import nbg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  nbg_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output nbg_out_t              m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [18:0] {
        ST_IDLE  = 19'h00001,
        ST_RDI   = 19'h00002,
        ST_LDI   = 19'h00004,
        ST_RDJ   = 19'h00008,
        ST_DIFF  = 19'h00010,
        ST_DX2   = 19'h00020,
        ST_DY2   = 19'h00040,
        ST_SQRT  = 19'h00080,
        ST_MM    = 19'h00100,
        ST_Q     = 19'h00200,
        ST_W     = 19'h00400,
        ST_NUM   = 19'h00800,
        ST_COMP  = 19'h01000,
        ST_NEXTJ = 19'h02000,
        ST_WRP   = 19'h04000,
        ST_CRD   = 19'h08000,
        ST_CWR   = 19'h10000,
        ST_ERD   = 19'h20000,
        ST_EMIT  = 19'h40000
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [IDX_W-1:0]          j_reg, j_next;
    logic [SPEED_W-1:0]        steps_reg, steps_next;
    logic signed [SPEED_W-1:0] tick_reg, tick_next;
    logic [CFG_DATA_W-1:0]     gconst_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      run_reg;
    logic                      alu_run_reg, alu_run_next;
    logic                      axis_reg, axis_next;
    logic                      m_valid_reg, m_valid_next;
    nbg_out_t                  m_data_reg, m_data_next;

    kin_t                      pi_reg, pi_next;
    coord_t                    ax_reg, ax_next;
    coord_t                    ay_reg, ay_next;
    coord_t                    dx_reg, dx_next;
    coord_t                    dy_reg, dy_next;
    logic [MASS_W-1:0]         mass_reg, mass_next;
    logic [D2_W-1:0]           d2_reg, d2_next;
    umag_t                     m_reg, m_next;
    logic [D2_W-1:0]           mm_reg, mm_next;
    logic [Q_W-1:0]            q_reg, q_next;
    logic [W_W-1:0]            w_reg, w_next;

    logic [CNT_W-1:0]          n_eff;
    logic                      i_last, j_last;
    logic signed [SPEED_W-1:0] tick_inc;
    logic                      alu_state;
    alu_req_t                  alu_req;
    alu_stat_t                 alu_stat;
    logic [ALU_W-1:0]          alu_opa, alu_opb, alu_res;
    logic [D2_W-1:0]           d2_sum;
    coord_t                    comp_mag, comp_val;

    logic                      kin_we, kin_re, mass_re, pend_we, pend_re;
    logic [IDX_W-1:0]          kin_waddr, kin_raddr;
    kin_t                      kin_wdata, kin_rdata, pend_wdata, pend_rdata, load_kin;
    logic [MASS_W-1:0]         mass_rdata;

    nbg_ram #(.WIDTH($bits(kin_t)), .DEPTH(MAX_BODIES)) u_kin_ram (
        .aclk    (aclk),
        .wr_en   (kin_we),
        .wr_addr (kin_waddr),
        .wr_data (kin_wdata),
        .rd_en   (kin_re),
        .rd_addr (kin_raddr),
        .rd_data (kin_rdata)
    );

    nbg_ram #(.WIDTH(MASS_W), .DEPTH(MAX_BODIES)) u_mass_ram (
        .aclk    (aclk),
        .wr_en   (kin_we && state_reg == ST_IDLE),
        .wr_addr (kin_waddr),
        .wr_data (s_data.body_mass),
        .rd_en   (mass_re),
        .rd_addr (kin_raddr),
        .rd_data (mass_rdata)
    );

    nbg_ram #(.WIDTH($bits(kin_t)), .DEPTH(MAX_BODIES)) u_pend_ram (
        .aclk    (aclk),
        .wr_en   (pend_we),
        .wr_addr (i_reg),
        .wr_data (pend_wdata),
        .rd_en   (pend_re),
        .rd_addr (i_reg),
        .rd_data (pend_rdata)
    );

    nbg_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .stat    (alu_stat),
        .res     (alu_res)
    );

    assign n_eff    = (count_reg > CNT_W'(MAX_BODIES)) ? CNT_W'(MAX_BODIES) : count_reg;
    assign i_last   = (CNT_W'(i_reg) == n_eff - CNT_W'(1));
    assign j_last   = (CNT_W'(j_reg) == n_eff - CNT_W'(1));
    assign tick_inc = (tick_reg <= 0) ? tick_reg + $signed(SPEED_W'(1)) : tick_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign load_kin.px = s_data.load_pos_x;
    assign load_kin.py = s_data.load_pos_y;
    assign load_kin.vx = s_data.load_vel_x;
    assign load_kin.vy = s_data.load_vel_y;

    assign pend_wdata.px = sat_add(sat_add(pi_reg.px, ax_reg), pi_reg.vx);
    assign pend_wdata.py = sat_add(sat_add(pi_reg.py, ay_reg), pi_reg.vy);
    assign pend_wdata.vx = sat_add(pi_reg.vx, ax_reg);
    assign pend_wdata.vy = sat_add(pi_reg.vy, ay_reg);

    assign d2_sum   = d2_reg + alu_res[D2_W-1:0];
    assign comp_mag = (|alu_res[ALU_W-1:COORD_WIDTH-1]) ? CMAX
                                                       : {1'b0, alu_res[COORD_WIDTH-2:0]};
    assign comp_val = (axis_reg ? dy_reg[COORD_WIDTH-1] : dx_reg[COORD_WIDTH-1])
                      ? -comp_mag : comp_mag;

    always_comb begin
        kin_re    = (state_reg == ST_RDI) || (state_reg == ST_ERD) ||
                    (state_reg == ST_RDJ && j_reg != i_reg);
        mass_re   = (state_reg == ST_RDJ && j_reg != i_reg);
        kin_raddr = (state_reg == ST_RDJ) ? j_reg : i_reg;
        pend_we   = (state_reg == ST_WRP);
        pend_re   = (state_reg == ST_CRD);
        if (state_reg == ST_CWR) begin
            kin_we    = 1'b1;
            kin_waddr = i_reg;
            kin_wdata = pend_rdata;
        end else begin
            kin_we    = s_valid && s_ready && s_data.command == CMD_LOAD;
            kin_waddr = s_data.body_index[IDX_W-1:0];
            kin_wdata = load_kin;
        end
    end

    always_comb begin
        alu_state = 1'b1;
        alu_req.op = ALU_MUL;
        alu_opa = '0;
        alu_opb = '0;
        case (state_reg)
            ST_DX2: begin
                alu_opa = ALU_W'(mag(dx_reg));
                alu_opb = ALU_W'(mag(dx_reg));
            end
            ST_DY2: begin
                alu_opa = ALU_W'(mag(dy_reg));
                alu_opb = ALU_W'(mag(dy_reg));
            end
            ST_SQRT: begin
                alu_req.op = ALU_SQRT;
                alu_opa = ALU_W'(d2_reg);
            end
            ST_MM: begin
                alu_opa = ALU_W'(m_reg);
                alu_opb = ALU_W'(m_reg);
            end
            ST_Q: begin
                alu_opa = ALU_W'(gconst_reg);
                alu_opb = ALU_W'(mass_reg);
            end
            ST_W: begin
                alu_req.op = ALU_DIV;
                alu_opa = ALU_W'({q_reg, {W_SHIFT{1'b0}}});
                alu_opb = ALU_W'(mm_reg);
            end
            ST_NUM: begin
                alu_opa = ALU_W'(w_reg);
                alu_opb = ALU_W'(axis_reg ? mag(dy_reg) : mag(dx_reg));
            end
            ST_COMP: begin
                // The product is still held in the unit when the quotient starts.
                alu_req.op = ALU_DIV;
                alu_opa = alu_res;
                alu_opb = ALU_W'(m_reg);
            end
            default: begin
                alu_state = 1'b0;
            end
        endcase
        alu_req.start = alu_state && !alu_run_reg;
    end

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        steps_next   = steps_reg;
        tick_next    = tick_reg;
        alu_run_next = alu_run_reg;
        axis_next    = axis_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pi_next      = pi_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        mass_next    = mass_reg;
        d2_next      = d2_reg;
        m_next       = m_reg;
        mm_next      = mm_reg;
        q_next       = q_reg;
        w_next       = w_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (alu_req.start) begin
            alu_run_next = 1'b1;
        end
        if (alu_stat.done) begin
            alu_run_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_data.command == CMD_TICK && run_reg) begin
                    if (tick_inc < 0) begin
                        tick_next = tick_inc;
                    end else begin
                        tick_next  = speed_reg;
                        steps_next = (speed_reg >= 0) ? $unsigned(speed_reg) + 1'b1
                                                      : SPEED_W'(1);
                        i_next     = '0;
                        if (n_eff != '0) begin
                            state_next = ST_RDI;
                        end
                    end
                end
            end
            ST_RDI: begin
                state_next = ST_LDI;
            end
            ST_LDI: begin
                pi_next    = kin_rdata;
                ax_next    = '0;
                ay_next    = '0;
                j_next     = '0;
                state_next = ST_RDJ;
            end
            ST_RDJ: begin
                state_next = (j_reg == i_reg) ? ST_NEXTJ : ST_DIFF;
            end
            ST_DIFF: begin
                dx_next    = sat_sub(kin_rdata.px, pi_reg.px);
                dy_next    = sat_sub(kin_rdata.py, pi_reg.py);
                mass_next  = mass_rdata;
                state_next = ST_DX2;
            end
            ST_DX2: begin
                if (alu_stat.done) begin
                    d2_next    = alu_res[D2_W-1:0];
                    state_next = ST_DY2;
                end
            end
            ST_DY2: begin
                if (alu_stat.done) begin
                    d2_next    = d2_sum;
                    state_next = (d2_sum == '0) ? ST_NEXTJ : ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (alu_stat.done) begin
                    m_next     = alu_res[COORD_WIDTH-1:0];
                    state_next = ST_MM;
                end
            end
            ST_MM: begin
                if (alu_stat.done) begin
                    mm_next    = alu_res[D2_W-1:0];
                    state_next = ST_Q;
                end
            end
            ST_Q: begin
                if (alu_stat.done) begin
                    q_next     = alu_res[Q_W-1:0];
                    state_next = ST_W;
                end
            end
            ST_W: begin
                if (alu_stat.done) begin
                    w_next     = (|alu_res[ALU_W-1:W_W]) ? {W_W{1'b1}} : alu_res[W_W-1:0];
                    axis_next  = 1'b0;
                    state_next = ST_NUM;
                end
            end
            ST_NUM: begin
                if (alu_stat.done) begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                if (alu_stat.done) begin
                    if (axis_reg) begin
                        ay_next    = sat_add(ay_reg, comp_val);
                        state_next = ST_NEXTJ;
                    end else begin
                        ax_next    = sat_add(ax_reg, comp_val);
                        axis_next  = 1'b1;
                        state_next = ST_NUM;
                    end
                end
            end
            ST_NEXTJ: begin
                if (j_last) begin
                    state_next = ST_WRP;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_RDJ;
                end
            end
            ST_WRP: begin
                if (i_last) begin
                    i_next     = '0;
                    state_next = ST_CRD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RDI;
                end
            end
            ST_CRD: begin
                state_next = ST_CWR;
            end
            ST_CWR: begin
                if (i_last) begin
                    i_next = '0;
                    if (steps_reg == SPEED_W'(1)) begin
                        state_next = ST_ERD;
                    end else begin
                        steps_next = steps_reg - 1'b1;
                        state_next = ST_RDI;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_CRD;
                end
            end
            ST_ERD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.out_index = 3'(i_reg);
                    m_data_next.out_pos_x = kin_rdata.px;
                    m_data_next.out_pos_y = kin_rdata.py;
                    m_data_next.out_vel_x = kin_rdata.vx;
                    m_data_next.out_vel_y = kin_rdata.vy;
                    m_data_next.last_body = i_last;
                    if (i_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tick_reg    <= '0;
            gconst_reg  <= CFG_DATA_W'(65536);
            speed_reg   <= '0;
            count_reg   <= CNT_W'(MAX_BODIES);
            run_reg     <= 1'b0;
            alu_run_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            alu_run_reg <= alu_run_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GRAVITY: gconst_reg <= cfg_wdata;
                    REG_SPEED:   speed_reg  <= cfg_wdata[SPEED_W-1:0];
                    REG_COUNT:   count_reg  <= cfg_wdata[CNT_W-1:0];
                    REG_RUN:     run_reg    <= cfg_wdata[0];
                    default:     run_reg    <= run_reg;
                endcase
            end
        end
        i_reg      <= i_next;
        j_reg      <= j_next;
        steps_reg  <= steps_next;
        axis_reg   <= axis_next;
        m_data_reg <= m_data_next;
        pi_reg     <= pi_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        mass_reg   <= mass_next;
        d2_reg     <= d2_next;
        m_reg      <= m_next;
        mm_reg     <= mm_next;
        q_reg      <= q_next;
        w_reg      <= w_next;
    end

`ifndef SYNTHESIS
    a_alu_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_req.start |-> !alu_stat.busy)
        else $error("arithmetic unit started while busy");

    a_alu_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_stat.done |-> alu_run_reg)
        else $error("arithmetic unit finished without a pending operation");

    a_no_self_pull: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIFF |-> j_reg != i_reg)
        else $error("body paired with itself");

    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result loaded outside the emit phase");
`endif

endmodule
